// ----- rtl/dual_protocol_serial_deframer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the serial deframer
// ----------------------------------------------------------------------------
`ifndef DUAL_PROTOCOL_SERIAL_DEFRAMER_MACROS_SVH
`define DUAL_PROTOCOL_SERIAL_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DPSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// dpsd_pkg
// Types and constants shared by the serial deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dpsd_pkg;

    localparam logic [7:0] HDR_MAVLINK = 8'hFE;
    localparam logic [7:0] HDR_TELEM   = 8'h73;

    // bytes after the MAVLink length byte besides the payload: 4 header + 2 CRC
    localparam logic [8:0] MAV_FIXED_AFTER_LEN = 9'd6;

    localparam logic [1:0] KIND_NOISE   = 2'd0;
    localparam logic [1:0] KIND_MAVLINK = 2'd1;
    localparam logic [1:0] KIND_TELEM   = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_LENGTH   = 3'd1,
        PH_MAV_BODY = 3'd2,
        PH_TEL_PAY  = 3'd3,
        PH_TEL_CRC  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       first;
        logic       last;
        logic       good;
    } tag_t;

endpackage

`default_nettype wire

// ----- rtl/dpsd_tagger.sv -----
// ----------------------------------------------------------------------------
// dpsd_tagger
// Frame tracking state machine: tags each accepted byte and advances state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_protocol_serial_deframer_macros.svh"

module dpsd_tagger (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    rx_byte,
    output dpsd_pkg::tag_t     tag
);
    import dpsd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [1:0] kind_reg, kind_next;
    logic [8:0] bytes_left_reg, bytes_left_next;
    logic [7:0] payload_left_reg, payload_left_next;
    logic [7:0] sum_reg, sum_next;

    logic [8:0] bytes_dec;
    logic [7:0] payload_dec;

    assign bytes_dec   = bytes_left_reg - 9'd1;
    assign payload_dec = payload_left_reg - 8'd1;

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        kind_next         = kind_reg;
        bytes_left_next   = bytes_left_reg;
        payload_left_next = payload_left_reg;
        sum_next          = sum_reg;
        case (phase_reg)
            PH_LENGTH:
            begin
                if (kind_reg == KIND_MAVLINK)
                begin
                    bytes_left_next = {1'b0, rx_byte} + MAV_FIXED_AFTER_LEN;
                    phase_next      = PH_MAV_BODY;
                end
                else
                begin
                    payload_left_next = rx_byte;
                    sum_next          = 8'd0;
                    phase_next        = (rx_byte == 8'd0) ? PH_TEL_CRC : PH_TEL_PAY;
                end
            end
            PH_MAV_BODY:
            begin
                bytes_left_next = bytes_dec;
                if (bytes_dec == 9'd0)
                begin
                    phase_next = PH_HUNT;
                    kind_next  = KIND_NOISE;
                end
            end
            PH_TEL_PAY:
            begin
                sum_next          = sum_reg + rx_byte;
                payload_left_next = payload_dec;
                if (payload_dec == 8'd0)
                    phase_next = PH_TEL_CRC;
            end
            PH_TEL_CRC:
            begin
                phase_next = PH_HUNT;
                kind_next  = KIND_NOISE;
            end
            default:
            begin
                // hunting; unused codes behave the same
                phase_next = PH_HUNT;
                if (rx_byte == HDR_MAVLINK)
                begin
                    kind_next  = KIND_MAVLINK;
                    phase_next = PH_LENGTH;
                end
                else if (rx_byte == HDR_TELEM)
                begin
                    kind_next  = KIND_TELEM;
                    phase_next = PH_LENGTH;
                end
            end
        endcase
    end

    // outputs
    always_comb
    begin
        tag = '0;
        case (phase_reg)
            PH_LENGTH:
                tag.kind = kind_reg;
            PH_MAV_BODY:
            begin
                tag.kind = KIND_MAVLINK;
                if (bytes_dec == 9'd0)
                begin
                    tag.last = 1'b1;
                    tag.good = 1'b1;
                end
            end
            PH_TEL_PAY:
                tag.kind = KIND_TELEM;
            PH_TEL_CRC:
            begin
                tag.kind = KIND_TELEM;
                tag.last = 1'b1;
                tag.good = (rx_byte == sum_reg);
            end
            default:
            begin
                if (rx_byte == HDR_MAVLINK)
                begin
                    tag.kind  = KIND_MAVLINK;
                    tag.first = 1'b1;
                end
                else if (rx_byte == HDR_TELEM)
                begin
                    tag.kind  = KIND_TELEM;
                    tag.first = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            kind_reg         <= KIND_NOISE;
            bytes_left_reg   <= '0;
            payload_left_reg <= '0;
            sum_reg          <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            kind_reg         <= kind_next;
            bytes_left_reg   <= bytes_left_next;
            payload_left_reg <= payload_left_next;
            sum_reg          <= sum_next;
        end
    end

    `DPSD_ASSERT_NEXT(a_first_to_length, clk, rst_n, step && tag.first, phase_reg == PH_LENGTH && kind_reg != KIND_NOISE, "header byte did not enter length phase")
    `DPSD_ASSERT_NEXT(a_last_to_hunt, clk, rst_n, step && tag.last, phase_reg == PH_HUNT && kind_reg == KIND_NOISE, "frame end did not return to hunting")
    `DPSD_ASSERT_NOW(a_good_on_last, clk, rst_n, tag.good, tag.last && tag.kind != KIND_NOISE, "good flag away from a frame end")

endmodule

`default_nettype wire

// ----- rtl/dual_protocol_serial_deframer.sv -----
// ----------------------------------------------------------------------------
// dual_protocol_serial_deframer
// Tags a serial byte stream as noise, MAVLink v1 frames or telemetry frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one received byte per
//   transaction. Output channel (out_valid / out_stall) returns the same byte
//   with frame_kind, frame_first, frame_last and frame_good, one result per
//   input byte, in order.
//   The result is registered: a byte accepted at a clock edge is loaded into
//   the output register at that edge. Throughput is one byte per cycle while
//   the receiver does not stall; the tag logic is a single pass through the
//   frame state machine, with the result held in one output register.
//   When the receiver stalls, the output register holds its transaction and
//   in_stall rises only while that register is full and stalled; a new byte
//   is taken in the same cycle the held one leaves.
//   Reset clears the output valid flag and puts the frame tracker in the
//   hunting state with a zero checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_protocol_serial_deframer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      data_byte,
    output logic [1:0]      frame_kind,
    output logic            frame_first,
    output logic            frame_last,
    output logic            frame_good
);
    import dpsd_pkg::*;

    logic       accept;
    tag_t       tag;
    logic       valid_reg;
    logic [7:0] byte_reg;
    tag_t       tag_reg;

    assign in_stall = valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    dpsd_tagger u_tagger (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .rx_byte (rx_byte),
        .tag     (tag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
            tag_reg  <= tag;
        end
    end

    assign out_valid   = valid_reg;
    assign data_byte   = byte_reg;
    assign frame_kind  = tag_reg.kind;
    assign frame_first = tag_reg.first;
    assign frame_last  = tag_reg.last;
    assign frame_good  = tag_reg.good;

endmodule

`default_nettype wire

// ----- bench/dpsd_tag_checker.sv -----
// ----------------------------------------------------------------------------
// dpsd_tag_checker
// Watches both channels of the serial deframer and tracks frame state on its
// own. Every accepted byte gets an expected tag. Each returned transaction is
// checked against the oldest expected tag.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsd_tag_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic [1:0] frame_kind,
    input  wire logic       frame_first,
    input  wire logic       frame_last,
    input  wire logic       frame_good,
    output int              errors,
    output int              pending,
    output int              results_seen,
    output int              good_frames,
    output int              bad_frames,
    output int              noise_bytes
);
    import dpsd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        tag_t       tag;
    } tagged_byte_t;

    // shadow frame tracker
    phase_t     st_phase = PH_HUNT;
    logic [1:0] st_kind  = KIND_NOISE;
    logic [8:0] st_left  = '0;
    logic [7:0] st_pay   = '0;
    logic [7:0] st_sum   = '0;

    tagged_byte_t tags_due[$];

    initial
    begin
        errors       = 0;
        pending      = 0;
        results_seen = 0;
        good_frames  = 0;
        bad_frames   = 0;
        noise_bytes  = 0;
    end

    // tag one byte and advance the shadow tracker
    function automatic tag_t tag_byte(input logic [7:0] b);
        tag_t t;
        t = '0;
        case (st_phase)
            PH_LENGTH:
            begin
                t.kind = st_kind;
                if (st_kind == KIND_MAVLINK)
                begin
                    st_left  = {1'b0, b} + MAV_FIXED_AFTER_LEN;
                    st_phase = PH_MAV_BODY;
                end
                else
                begin
                    st_pay   = b;
                    st_sum   = '0;
                    st_phase = (b == 8'd0) ? PH_TEL_CRC : PH_TEL_PAY;
                end
            end
            PH_MAV_BODY:
            begin
                t.kind  = KIND_MAVLINK;
                st_left = st_left - 9'd1;
                if (st_left == 9'd0)
                begin
                    t.last   = 1'b1;
                    t.good   = 1'b1;
                    st_phase = PH_HUNT;
                    st_kind  = KIND_NOISE;
                end
            end
            PH_TEL_PAY:
            begin
                t.kind = KIND_TELEM;
                st_sum = st_sum + b;
                st_pay = st_pay - 8'd1;
                if (st_pay == 8'd0)
                    st_phase = PH_TEL_CRC;
            end
            PH_TEL_CRC:
            begin
                t.kind   = KIND_TELEM;
                t.last   = 1'b1;
                t.good   = (b == st_sum);
                st_phase = PH_HUNT;
                st_kind  = KIND_NOISE;
            end
            default:
            begin
                if (b == HDR_MAVLINK)
                begin
                    t.kind   = KIND_MAVLINK;
                    t.first  = 1'b1;
                    st_kind  = KIND_MAVLINK;
                    st_phase = PH_LENGTH;
                end
                else if (b == HDR_TELEM)
                begin
                    t.kind   = KIND_TELEM;
                    t.first  = 1'b1;
                    st_kind  = KIND_TELEM;
                    st_phase = PH_LENGTH;
                end
                else
                    st_phase = PH_HUNT;
            end
        endcase
        return t;
    endfunction

    task automatic flag_field(input string name, input int unsigned want,
                              input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tagged_byte_t due;
        if (!rst_n)
        begin
            st_phase = PH_HUNT;
            st_kind  = KIND_NOISE;
            st_left  = '0;
            st_pay   = '0;
            st_sum   = '0;
            tags_due.delete();
            pending  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                due.data = rx_byte;
                due.tag  = tag_byte(rx_byte);
                tags_due.push_back(due);
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (frame_last)
                begin
                    if (frame_good)
                        good_frames++;
                    else
                        bad_frames++;
                end
                if (frame_kind == KIND_NOISE)
                    noise_bytes++;
                if (tags_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction, actual byte %0h", $time, data_byte);
                end
                else
                begin
                    due = tags_due.pop_front();
                    flag_field("data_byte", 32'(due.data), 32'(data_byte));
                    flag_field("frame_kind", 32'(due.tag.kind), 32'(frame_kind));
                    flag_field("frame_first", 32'(due.tag.first), 32'(frame_first));
                    flag_field("frame_last", 32'(due.tag.last), 32'(frame_last));
                    flag_field("frame_good", 32'(due.tag.good), 32'(frame_good));
                end
            end
            pending = tags_due.size();
        end
    end

endmodule

`default_nettype wire

// ----- bench/tb_dual_protocol_serial_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_dual_protocol_serial_deframer
// Drives byte streams of noise, MAVLink frames (zero and maximum lengths) and
// telemetry frames (good and bad checksums, zero lengths) with random gaps and
// output stalls; the checker module predicts every tag and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dual_protocol_serial_deframer;

    import dpsd_pkg::*;

    localparam int LONG_HOLD    = 40;
    localparam int STREAM_BYTES = 450;
    localparam int CALM_FROM    = 390;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] data_byte;
    logic [1:0] frame_kind;
    logic       frame_first;
    logic       frame_last;
    logic       frame_good;

    int errors;
    int pending;
    int results_seen;
    int good_frames;
    int bad_frames;
    int noise_bytes;

    logic in_fire;
    bit   hold_req = 1'b0;
    bit   calm     = 1'b0;
    int   sent     = 0;

    dual_protocol_serial_deframer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_byte  (data_byte),
        .frame_kind (frame_kind),
        .frame_first(frame_first),
        .frame_last (frame_last),
        .frame_good (frame_good)
    );

    dpsd_tag_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_byte   (data_byte),
        .frame_kind  (frame_kind),
        .frame_first (frame_first),
        .frame_last  (frame_last),
        .frame_good  (frame_good),
        .errors      (errors),
        .pending     (pending),
        .results_seen(results_seen),
        .good_frames (good_frames),
        .bad_frames  (bad_frames),
        .noise_bytes (noise_bytes)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // input transaction seen at the last rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
            in_fire <= in_valid && !in_stall;
    end

    initial
    begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stall bursts, quiet stretches, one long hold-off
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(20, 60)) @(negedge clk);
        end
    end

    // called at a falling edge; returns at a falling edge after acceptance and any random gap
    task automatic send_byte(input logic [7:0] b);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(negedge clk);
        while (!in_fire);
        sent++;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
    endtask

    function automatic logic [7:0] pick_payload();
        logic [7:0] b;
        case ($urandom_range(0, 15))
            0:       b = HDR_MAVLINK;
            1:       b = HDR_TELEM;
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pick_len();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(13, 40))
                                           : 8'($urandom_range(0, 12));
    endfunction

    task automatic send_telem(input logic [7:0] len, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = '0;
        send_byte(HDR_TELEM);
        send_byte(len);
        for (int i = 0; i < int'(len); i++)
        begin
            b = pick_payload();
            sum += b;
            send_byte(b);
        end
        send_byte(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
    endtask

    task automatic send_mav(input logic [7:0] len);
        send_byte(HDR_MAVLINK);
        send_byte(len);
        for (int i = 0; i < int'(len) + 6; i++)
            send_byte(pick_payload());
    endtask

    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            do
                b = 8'($urandom);
            while (b == HDR_MAVLINK || b == HDR_TELEM);
            send_byte(b);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] opening[$];
        int         frame_no;
        int         pick;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = '0;
        // noise extremes, MAVLink with zero length and header values in it,
        // zero-length telemetry good and bad, header values as telemetry
        // payload, bad checksum
        opening = '{8'h00, 8'hFF, 8'h55, 8'hAA,
                    HDR_MAVLINK, 8'h00, HDR_TELEM, HDR_MAVLINK, 8'h01, 8'h02, 8'h03, 8'h04,
                    HDR_TELEM, 8'h00, 8'h00,
                    HDR_TELEM, 8'h00, 8'h05,
                    HDR_TELEM, 8'h02, HDR_MAVLINK, HDR_TELEM, 8'h71,
                    HDR_TELEM, 8'h01, 8'h10, 8'h11};
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening[i])
            send_byte(opening[i]);

        frame_no = 0;
        while (sent < STREAM_BYTES)
        begin
            if (frame_no == 2)
                hold_req = 1'b1;
            if (frame_no == 8)
                drain();
            if (sent > CALM_FROM)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (frame_no == 4)
                send_mav(8'hFF);
            else if (pick < 45)
                send_telem(pick_len(), 1'b0);
            else if (pick < 55)
                send_telem(pick_len(), 1'b1);
            else if (pick < 85)
                send_mav(pick_len());
            else
                send_noise($urandom_range(1, 4));
            frame_no++;
        end

        drain();
        repeat (4) @(negedge clk);
        $display("Sent %0d bytes in %0d frames plus noise; %0d tags returned.",
                 sent, frame_no, results_seen);
        $display("Frames closed good: %0d, bad: %0d; noise bytes: %0d.",
                 good_frames, bad_frames, noise_bytes);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
